// ===== rtl/mdks_pkg.sv =====
package mdks_pkg;

	// default geometry of the display and key matrix
	localparam int DIGITS_DEF    = 8;
	localparam int CATHODES_DEF  = 8;
	localparam int KEY_LINES_DEF = 4;

	// fixed field widths
	localparam int ACTION_W  = 2;
	localparam int INDEX_W   = 3;
	localparam int WORD_W    = 8;
	localparam int SAMPLE_W  = 4;
	localparam int KEY_W     = 32;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// register map (byte addresses)
	localparam logic [APB_AW-1:0] ADDR_AVERAGE_ENABLE = 3'd0;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_LOCK  = 2'd1,
		ACT_SCAN  = 2'd2
	} action_t;

endpackage

// ===== rtl/multiplexed_display_key_scanner_top.sv =====
// Multiplexed LED display and key matrix scanner. Each input beat is one
// action: write a cathode word into the display RAM, set the shadow lock,
// or run one scan slot. Only a scan slot yields a result beat, carrying the
// digit driven, its shadow cathode word, the latched key word and a frame
// end flag. An accepted beat passes an input register, is worked against
// the scanner state and lands in an output register, so one beat per cycle
// is sustained while no result waits on a stalled output. Such a result
// holds the next scan beat in the input register, and every beat behind
// it; write and lock beats ahead of that scan keep flowing.
// average_enable (address 0) makes the key word latch only when two
// consecutive frames agree.
module multiplexed_display_key_scanner_top #(
	parameter int DIGITS    = mdks_pkg::DIGITS_DEF,
	parameter int CATHODES  = mdks_pkg::CATHODES_DEF,
	parameter int KEY_LINES = mdks_pkg::KEY_LINES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mdks_pkg::APB_AW-1:0]   paddr,
	input  logic [mdks_pkg::APB_DW-1:0]   pwdata,
	output logic [mdks_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mdks_pkg::ACTION_W-1:0] action,
	input  logic [mdks_pkg::INDEX_W-1:0]  digit_index,
	input  logic [mdks_pkg::WORD_W-1:0]   word_value,
	input  logic                          lock_value,
	input  logic [mdks_pkg::SAMPLE_W-1:0] key_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mdks_pkg::INDEX_W-1:0]  anode_index,
	output logic [mdks_pkg::WORD_W-1:0]   cathode_drive,
	output logic [mdks_pkg::KEY_W-1:0]    key_levels,
	output logic                          frame_done
);
	import mdks_pkg::*;

	localparam int DigitW  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int KeyUse  = (KEY_LINES < SAMPLE_W) ? KEY_LINES : SAMPLE_W;
	localparam logic [WORD_W-1:0] CathMask =
		(CATHODES >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((1 << CATHODES) - 1);

	// configuration
	logic average_enable_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_AVERAGE_ENABLE);
	assign prdata = (paddr == ADDR_AVERAGE_ENABLE) ?
		{{(APB_DW-1){1'b0}}, average_enable_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			average_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			average_enable_q <= pwdata[0];
		end
	end

	// input register
	logic                  valid_s1;
	action_t               action_s1;
	logic [INDEX_W-1:0]    index_s1;
	logic [WORD_W-1:0]     word_s1;
	logic                  lock_s1;
	logic [SAMPLE_W-1:0]   sample_s1;

	logic out_free;
	logic fire_s1;
	logic take_in;
	logic is_scan;

	assign out_free = !out_valid || !out_stall;
	assign is_scan  = (action_s1 == ACT_SCAN);
	assign fire_s1  = valid_s1 && (!is_scan || out_free);
	assign in_stall = valid_s1 && !fire_s1;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= action_t'(action);
			index_s1  <= digit_index;
			word_s1   <= word_value;
			lock_s1   <= lock_value;
			sample_s1 <= key_sample;
		end
	end

	// scanner state
	logic [WORD_W-1:0] display_q [DIGITS];
	logic [WORD_W-1:0] shadow_q  [DIGITS];
	logic [DigitW-1:0] scan_digit_q;
	logic [KEY_W-1:0]  key_accum_q;
	logic [KEY_W-1:0]  key_previous_q;
	logic [KEY_W-1:0]  key_latched_q;
	logic              lock_q;

	logic [DigitW:0]   digit_inc;
	logic              wrap;
	logic [DigitW-1:0] digit_next;
	logic [KEY_W-1:0]  key_hits;
	logic [KEY_W-1:0]  accum_new;
	logic [KEY_W-1:0]  latched_new;
	logic              write_ok;

	assign digit_inc  = {1'b0, scan_digit_q} + 1'b1;
	assign wrap       = (digit_inc == (DigitW+1)'(DIGITS));
	assign digit_next = wrap ? '0 : digit_inc[DigitW-1:0];
	assign accum_new  = key_accum_q | key_hits;
	assign write_ok   = (32'(index_s1) < 32'(DIGITS));

	// place this row's key lines at their bits of the frame word
	always_comb begin
		int pos;
		key_hits = '0;
		for (int i = 0; i < KeyUse; i++) begin
			pos = i + KEY_LINES * int'(scan_digit_q);
			if (sample_s1[i] && pos < KEY_W) begin
				key_hits[pos[4:0]] = 1'b1;
			end
		end
	end

	always_comb begin
		latched_new = key_latched_q;
		if (wrap) begin
			if (!average_enable_q || accum_new == key_previous_q) begin
				latched_new = accum_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIGITS; d++) begin
				display_q[d] <= '0;
				shadow_q[d]  <= '0;
			end
			scan_digit_q   <= '0;
			key_accum_q    <= '0;
			key_previous_q <= '0;
			key_latched_q  <= '0;
			lock_q         <= 1'b0;
		end else if (fire_s1) begin
			case (action_s1)
				ACT_WRITE: begin
					if (write_ok) begin
						display_q[DigitW'(index_s1)] <= word_s1;
					end
				end
				ACT_LOCK: begin
					lock_q <= lock_s1;
				end
				ACT_SCAN: begin
					scan_digit_q  <= digit_next;
					key_latched_q <= latched_new;
					if (wrap) begin
						key_accum_q <= '0;
						if (average_enable_q) begin
							key_previous_q <= accum_new;
						end
					end else begin
						key_accum_q <= accum_new;
					end
					// refresh the next digit's shadow unless locked
					if (!lock_q) begin
						shadow_q[digit_next] <= display_q[digit_next];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	logic fire_out;

	assign fire_out = fire_s1 && is_scan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_out) begin
			anode_index   <= INDEX_W'(scan_digit_q);
			cathode_drive <= shadow_q[scan_digit_q] & CathMask;
			key_levels    <= latched_new;
			frame_done    <= wrap;
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import mdks_pkg::*;

	localparam int NUM_DIGITS = DIGITS_DEF;
	localparam int KEY_LINES  = KEY_LINES_DEF;
	localparam int LATENCY    = 2;
	localparam int LIMIT      = 500000;

	// action code the block has no use for
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [INDEX_W-1:0]  digit;
		logic [WORD_W-1:0]   word;
		logic                lock;
		logic [SAMPLE_W-1:0] keys;
	} panel_beat_t;

	typedef struct packed {
		logic [INDEX_W-1:0] anode;
		logic [WORD_W-1:0]  cathode;
		logic [KEY_W-1:0]   keys;
		logic               done;
	} slot_result_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                psel        = 1'b0;
	logic                penable     = 1'b0;
	logic                pwrite      = 1'b0;
	logic [APB_AW-1:0]   paddr       = '0;
	logic [APB_DW-1:0]   pwdata      = '0;
	logic                in_valid    = 1'b0;
	logic [ACTION_W-1:0] action      = '0;
	logic [INDEX_W-1:0]  digit_index = '0;
	logic [WORD_W-1:0]   word_value  = '0;
	logic                lock_value  = 1'b0;
	logic [SAMPLE_W-1:0] key_sample  = '0;
	logic                out_stall   = 1'b0;

	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               in_stall;
	logic               out_valid;
	logic [INDEX_W-1:0] anode_index;
	logic [WORD_W-1:0]  cathode_drive;
	logic [KEY_W-1:0]   key_levels;
	logic               frame_done;

	multiplexed_display_key_scanner_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.digit_index  (digit_index),
		.word_value   (word_value),
		.lock_value   (lock_value),
		.key_sample   (key_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.anode_index  (anode_index),
		.cathode_drive(cathode_drive),
		.key_levels   (key_levels),
		.frame_done   (frame_done)
	);

	always #5 clk = ~clk;

	panel_beat_t  beat_queue[$];
	slot_result_t slot_due[$];

	// scanner mirror
	logic [WORD_W-1:0] display_mem[NUM_DIGITS] = '{default: '0};
	logic [WORD_W-1:0] shadow_mem[NUM_DIGITS]  = '{default: '0};
	int unsigned       scan_pos  = 0;
	logic [KEY_W-1:0]  key_frame = '0;
	logic [KEY_W-1:0]  key_prior = '0;
	logic [KEY_W-1:0]  key_held  = '0;
	logic              frozen    = 1'b0;
	logic              avg_mode  = 1'b0;

	int          errors    = 0;
	int          cycles    = 0;
	bit          calm      = 1'b0;
	int          gap_left  = 0;
	int          hold_left = 0;
	panel_beat_t feed_beat;
	panel_beat_t taken;
	slot_result_t want;

	// key pattern per digit, kept across frames so averaging can latch
	logic [SAMPLE_W-1:0] key_plan[NUM_DIGITS];
	int unsigned         plan_digit = 0;

	function automatic void scanner_step(input panel_beat_t b);
		slot_result_t r;
		int unsigned cur;
		case (b.action)
			ACT_WRITE: if (b.digit < NUM_DIGITS) display_mem[b.digit] = b.word;
			ACT_LOCK: frozen = b.lock;
			ACT_SCAN: begin
				cur = scan_pos;
				r.anode = cur[INDEX_W-1:0];
				r.cathode = shadow_mem[cur];
				for (int i = 0; i < KEY_LINES; i++)
					if (b.keys[i] && i + KEY_LINES * cur < KEY_W)
						key_frame[i + KEY_LINES * cur] = 1'b1;
				cur++;
				r.done = (cur >= NUM_DIGITS);
				if (r.done) begin
					cur = 0;
					if (!avg_mode || key_frame == key_prior)
						key_held = key_frame;
					if (avg_mode)
						key_prior = key_frame;
					key_frame = '0;
				end
				scan_pos = cur;
				if (!frozen)
					shadow_mem[cur] = display_mem[cur];
				r.keys = key_held;
				slot_due.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [KEY_W-1:0] exp_v,
			input logic [KEY_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			errors++;
		end
	endfunction

	function automatic panel_beat_t beat(input logic [ACTION_W-1:0] act, input int digit,
			input int word, input logic lock, input int keys);
		panel_beat_t b;
		b.action = act;
		b.digit = INDEX_W'(digit);
		b.word = WORD_W'(word);
		b.lock = lock;
		b.keys = SAMPLE_W'(keys);
		return b;
	endfunction

	// track which digit the next scan hits so steady patterns line up with frames
	task automatic queue_beat(input panel_beat_t b);
		if (b.action == ACT_SCAN)
			plan_digit = (plan_digit + 1) % NUM_DIGITS;
		beat_queue.push_back(b);
	endtask

	function automatic panel_beat_t random_beat(input bit steady);
		panel_beat_t b;
		int unsigned pick;
		b.digit = INDEX_W'($urandom_range(0, 7));
		b.word = WORD_W'($urandom_range(0, 255));
		b.lock = 1'($urandom_range(0, 1));
		b.keys = SAMPLE_W'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 12)
			b.action = ACT_WRITE;
		else if (pick < 17)
			b.action = ACT_LOCK;
		else if (pick < 19)
			b.action = ACT_UNUSED;
		else begin
			b.action = ACT_SCAN;
			if (plan_digit == 0 && $urandom_range(0, 2) == 0)
				foreach (key_plan[d])
					key_plan[d] = SAMPLE_W'($urandom_range(0, 15));
			// mostly repeat the plan, now and then break the frame
			if (steady && $urandom_range(0, 19) != 0)
				b.keys = key_plan[plan_digit];
		end
		return b;
	endfunction

	task automatic drain();
		while (beat_queue.size() != 0 || in_valid || slot_due.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_average(input logic val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_AVERAGE_ENABLE;
		pwdata <= {{(APB_DW-1){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		avg_mode = val;
	endtask

	// input driver: hold the beat while stalled, then take the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (beat_queue.size() != 0) begin
				feed_beat = beat_queue.pop_front();
				in_valid <= 1'b1;
				action <= feed_beat.action;
				digit_index <= feed_beat.digit;
				word_value <= feed_beat.word;
				lock_value <= feed_beat.lock;
				key_sample <= feed_beat.keys;
				if (!calm && $urandom_range(0, 9) == 0)
					gap_left <= $urandom_range(1, 17);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output backpressure in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			hold_left <= $urandom_range(1, 17) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				taken.action = action;
				taken.digit = digit_index;
				taken.word = word_value;
				taken.lock = lock_value;
				taken.keys = key_sample;
				scanner_step(taken);
			end
			if (out_valid && !out_stall) begin
				if (slot_due.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					want = slot_due.pop_front();
					check_field("anode_index", KEY_W'(want.anode), KEY_W'(anode_index));
					check_field("cathode_drive", KEY_W'(want.cathode),
						KEY_W'(cathode_drive));
					check_field("key_levels", want.keys, key_levels);
					check_field("frame_done", KEY_W'(want.done), KEY_W'(frame_done));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		foreach (key_plan[d])
			key_plan[d] = SAMPLE_W'($urandom_range(0, 15));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill every digit with edge patterns, then a full frame of scans
		queue_beat(beat(ACT_WRITE, 0, 8'hFF, 1'b0, 0));
		queue_beat(beat(ACT_WRITE, 1, 8'h00, 1'b1, 15));
		queue_beat(beat(ACT_WRITE, 2, 8'hAA, 1'b0, 0));
		queue_beat(beat(ACT_WRITE, 3, 8'h55, 1'b1, 15));
		queue_beat(beat(ACT_WRITE, 4, 8'h01, 1'b0, 0));
		queue_beat(beat(ACT_WRITE, 5, 8'h80, 1'b1, 15));
		queue_beat(beat(ACT_WRITE, 6, 8'h7F, 1'b0, 0));
		queue_beat(beat(ACT_WRITE, 7, 8'hFE, 1'b1, 15));
		for (int s = 0; s < NUM_DIGITS; s++)
			queue_beat(beat(ACT_SCAN, 7 - s, 8'hFF - s, s[0], s[0] ? 0 : 15));
		// freeze the shadow, write behind it, poke the unused code
		queue_beat(beat(ACT_LOCK, 7, 8'hFF, 1'b1, 15));
		queue_beat(beat(ACT_WRITE, 3, 8'h3C, 1'b0, 0));
		queue_beat(beat(ACT_UNUSED, 7, 8'hFF, 1'b1, 15));
		for (int s = 0; s < 4; s++)
			queue_beat(beat(ACT_SCAN, 0, 8'h00, 1'b0, 1 << s));
		queue_beat(beat(ACT_LOCK, 0, 8'h00, 1'b0, 0));
		drain();

		@(negedge clk);
		repeat (250) queue_beat(random_beat(1'b0));
		drain();

		write_average(1'b1);
		@(negedge clk);
		repeat (300) queue_beat(random_beat(1'b1));
		drain();

		write_average(1'b0);
		@(negedge clk);
		repeat (150) queue_beat(random_beat(1'($urandom_range(0, 1))));
		drain();

		write_average(1'b1);
		@(negedge clk);
		calm = 1'b1;
		repeat (250) queue_beat(random_beat(1'b1));
		drain();

		if (errors == 0 && slot_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
